>>> sv/crpe_pkg.sv
// Shared widths, types and constants for the Catmull-Rom point evaluator.
// No dependencies; every other file of the block imports this package.
package crpe_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int T_FRAC_BITS = 16;

	// t carries one integer bit so that exactly one can be represented
	localparam int T_W = T_FRAC_BITS + 1;

	// polynomial coefficients: 2p1, p2-p0, 2p0-5p1+4p2-p3, -p0+3p1-3p2+p3
	localparam int CA_W = SAMPLE_BITS + 1;
	localparam int CB_W = SAMPLE_BITS + 1;
	localparam int CC_W = SAMPLE_BITS + 4;
	localparam int CD_W = SAMPLE_BITS + 4;

	// Horner accumulators, scales 2^F, 2^2F, 2^3F
	localparam int ACC1_W = SAMPLE_BITS + T_FRAC_BITS + 5;
	localparam int LO1_W  = ACC1_W / 2;
	localparam int HI1_W  = ACC1_W - LO1_W;
	localparam int ACC2_W = ACC1_W + T_FRAC_BITS + 1;
	localparam int LO2_W  = ACC2_W / 2;
	localparam int HI2_W  = ACC2_W - LO2_W;
	localparam int ACC3_W = ACC2_W + T_FRAC_BITS + 1;

	// final scale is 2*2^(3F); the integer part sits above RND_SH
	localparam int RND_SH = 3 * T_FRAC_BITS + 1;
	localparam int Q_W    = ACC3_W - RND_SH;

	localparam int NSTAGES = 7;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [T_W-1:0] tparam_t;

	localparam tparam_t T_ONE = tparam_t'(1) << T_FRAC_BITS;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef struct packed {
		logic [NSTAGES-1:0] en;   // stage register may load this cycle
		logic [NSTAGES-1:0] vld;  // stage register holds a live item
	} pipe_ctl_t;

endpackage

>>> sv/crpe_if.sv
// Valid/ready channel interfaces for the Catmull-Rom point evaluator.
// Depends on crpe_pkg for the payload types.
interface crpe_in_if;
	import crpe_pkg::*;

	logic    valid;
	logic    ready;
	sample_t ctrl_prev;
	sample_t seg_start;
	sample_t seg_end;
	sample_t ctrl_next;
	tparam_t param_t;

	modport source (output valid, ctrl_prev, seg_start, seg_end, ctrl_next, param_t,
		input ready);
	modport sink (input valid, ctrl_prev, seg_start, seg_end, ctrl_next, param_t,
		output ready);
endinterface

interface crpe_out_if;
	import crpe_pkg::*;

	logic    valid;
	logic    ready;
	sample_t curve_value;
	logic    clipped;

	modport source (output valid, curve_value, clipped, input ready);
	modport sink (input valid, curve_value, clipped, output ready);
endinterface

>>> sv/crpe_pipe_ctrl.sv
// Valid bits and per-stage load enables for the evaluator pipeline.
// Depends on crpe_pkg (NSTAGES, pipe_ctl_t).
module crpe_pipe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_ready,
	output logic               in_ready,
	output crpe_pkg::pipe_ctl_t ctl
);
	import crpe_pkg::*;

	logic [NSTAGES-1:0] vld_q;
	logic [NSTAGES-1:0] en;

	// a stage loads when empty or when the stage after it moves on
	always_comb begin
		en[NSTAGES-1] = !vld_q[NSTAGES-1] || out_ready;
		for (int k = NSTAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready = en[0];
	assign ctl      = '{en: en, vld: vld_q};

endmodule

>>> sv/catmull_rom_point_eval.sv
// Top level of the uniform Catmull-Rom point evaluator: seven-stage datapath.
// Depends on crpe_pkg, crpe_if (channels) and crpe_pipe_ctrl (valid/enable chain).
//
//   channel   dir  payload                                          transfer
//   samples   in   ctrl_prev, seg_start, seg_end, ctrl_next,        valid & ready
//                  param_t (Q1.16, clamped to one)
//   result    out  curve_value (rounded, saturated), clipped        valid & ready
//
// One item per clock sustained while result is ready. An input transfer loads s1;
// the item then moves through s2 to s6 into s7, the output register, whose valid
// bit drives result valid. The seven stages come from splitting the Horner chain.
// Reset clears only the stage valid bits; datapath registers are not reset.
// Each stage has its own load enable, so bubbles are squeezed out while the
// output is stalled and nothing is dropped or duplicated.
module catmull_rom_point_eval (
	input  logic   clk,
	input  logic   arst_n,
	crpe_in_if.sink     samples,
	crpe_out_if.source  result
);
	import crpe_pkg::*;

	localparam logic [ACC3_W-1:0] RND_HALF = {{(ACC3_W-1){1'b0}}, 1'b1} << (3 * T_FRAC_BITS);

	pipe_ctl_t ctl;

	crpe_pipe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.out_ready(result.ready),
		.in_ready (samples.ready),
		.ctl      (ctl)
	);

	// ---------------------------------------------------------------
	// s1: coefficients of the cubic, clamp t to one
	// ---------------------------------------------------------------
	logic signed [CC_W-1:0] e0, e1, e2, e3;
	logic signed [CA_W-1:0] ca_c;
	logic signed [CB_W-1:0] cb_c;
	logic signed [CC_W-1:0] cc_c;
	logic signed [CD_W-1:0] cd_c;
	tparam_t                t_c;

	assign e0 = CC_W'(samples.ctrl_prev);
	assign e1 = CC_W'(samples.seg_start);
	assign e2 = CC_W'(samples.seg_end);
	assign e3 = CC_W'(samples.ctrl_next);

	assign ca_c = CA_W'(samples.seg_start) <<< 1;
	assign cb_c = CB_W'(samples.seg_end) - CB_W'(samples.ctrl_prev);
	assign cc_c = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
	assign cd_c = CD_W'((e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0);

	// any value with the integer bit set is one or above
	assign t_c = samples.param_t[T_FRAC_BITS] ? T_ONE : samples.param_t;

	logic signed [CA_W-1:0] ca_s1;
	logic signed [CB_W-1:0] cb_s1;
	logic signed [CC_W-1:0] cc_s1;
	logic signed [CD_W-1:0] cd_s1;
	tparam_t                t_s1;

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			ca_s1 <= ca_c;
			cb_s1 <= cb_c;
			cc_s1 <= cc_c;
			cd_s1 <= cd_c;
			t_s1  <= t_c;
		end
	end

	// ---------------------------------------------------------------
	// s2: acc1 = cd*t + cc*2^F
	// ---------------------------------------------------------------
	logic signed [CD_W+T_W:0]   m1_c;
	logic signed [ACC1_W-1:0]   acc1_c;

	assign m1_c   = cd_s1 * $signed({1'b0, t_s1});
	assign acc1_c = ACC1_W'(m1_c) + (ACC1_W'(cc_s1) <<< T_FRAC_BITS);

	logic signed [ACC1_W-1:0] acc1_s2;
	logic signed [CA_W-1:0]   ca_s2;
	logic signed [CB_W-1:0]   cb_s2;
	tparam_t                  t_s2;

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			acc1_s2 <= acc1_c;
			ca_s2   <= ca_s1;
			cb_s2   <= cb_s1;
			t_s2    <= t_s1;
		end
	end

	// ---------------------------------------------------------------
	// s3: acc1*t as two partial products (signed high half, unsigned low half)
	// ---------------------------------------------------------------
	logic signed [HI1_W-1:0]      a1_hi;
	logic [LO1_W-1:0]             a1_lo;
	logic signed [HI1_W+T_W:0]    ph1_c;
	logic [LO1_W+T_W-1:0]         pl1_c;

	assign a1_hi = acc1_s2[ACC1_W-1:LO1_W];
	assign a1_lo = acc1_s2[LO1_W-1:0];
	assign ph1_c = a1_hi * $signed({1'b0, t_s2});
	assign pl1_c = a1_lo * t_s2;

	logic signed [HI1_W+T_W:0] ph1_s3;
	logic [LO1_W+T_W-1:0]      pl1_s3;
	logic signed [CA_W-1:0]    ca_s3;
	logic signed [CB_W-1:0]    cb_s3;
	tparam_t                   t_s3;

	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			ph1_s3 <= ph1_c;
			pl1_s3 <= pl1_c;
			ca_s3  <= ca_s2;
			cb_s3  <= cb_s2;
			t_s3   <= t_s2;
		end
	end

	// ---------------------------------------------------------------
	// s4: acc2 = acc1*t + cb*2^2F
	// ---------------------------------------------------------------
	logic signed [ACC2_W-1:0] acc2_c;

	assign acc2_c = (ACC2_W'(ph1_s3) <<< LO1_W) + ACC2_W'(pl1_s3)
		+ (ACC2_W'(cb_s3) <<< (2 * T_FRAC_BITS));

	logic signed [ACC2_W-1:0] acc2_s4;
	logic signed [CA_W-1:0]   ca_s4;
	tparam_t                  t_s4;

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			acc2_s4 <= acc2_c;
			ca_s4   <= ca_s3;
			t_s4    <= t_s3;
		end
	end

	// ---------------------------------------------------------------
	// s5: acc2*t as two partial products
	// ---------------------------------------------------------------
	logic signed [HI2_W-1:0]      a2_hi;
	logic [LO2_W-1:0]             a2_lo;
	logic signed [HI2_W+T_W:0]    ph2_c;
	logic [LO2_W+T_W-1:0]         pl2_c;

	assign a2_hi = acc2_s4[ACC2_W-1:LO2_W];
	assign a2_lo = acc2_s4[LO2_W-1:0];
	assign ph2_c = a2_hi * $signed({1'b0, t_s4});
	assign pl2_c = a2_lo * t_s4;

	logic signed [HI2_W+T_W:0] ph2_s5;
	logic [LO2_W+T_W-1:0]      pl2_s5;
	logic signed [CA_W-1:0]    ca_s5;

	always_ff @(posedge clk) begin
		if (ctl.en[4]) begin
			ph2_s5 <= ph2_c;
			pl2_s5 <= pl2_c;
			ca_s5  <= ca_s4;
		end
	end

	// ---------------------------------------------------------------
	// s6: acc3 = acc2*t + ca*2^3F + half, keep the integer part
	// ---------------------------------------------------------------
	logic signed [ACC3_W-1:0] acc3_c;

	assign acc3_c = (ACC3_W'(ph2_s5) <<< LO2_W) + ACC3_W'(pl2_s5)
		+ (ACC3_W'(ca_s5) <<< (3 * T_FRAC_BITS)) + RND_HALF;

	logic signed [Q_W-1:0] q_s6;

	always_ff @(posedge clk) begin
		if (ctl.en[5]) begin
			q_s6 <= acc3_c[ACC3_W-1:RND_SH];
		end
	end

	// ---------------------------------------------------------------
	// s7: saturate to the sample range; this is the output register
	// ---------------------------------------------------------------
	logic [Q_W-SAMPLE_BITS:0] q_top;
	logic                     ovf_c;
	sample_t                  sat_c;

	assign q_top = q_s6[Q_W-1:SAMPLE_BITS-1];
	assign ovf_c = !((&q_top) || !(|q_top));
	assign sat_c = ovf_c ? (q_s6[Q_W-1] ? SAMPLE_MIN : SAMPLE_MAX) : q_s6[SAMPLE_BITS-1:0];

	sample_t curve_s7;
	logic    clip_s7;

	always_ff @(posedge clk) begin
		if (ctl.en[6]) begin
			curve_s7 <= sat_c;
			clip_s7  <= ovf_c;
		end
	end

	assign result.valid       = ctl.vld[NSTAGES-1];
	assign result.curve_value = curve_s7;
	assign result.clipped     = clip_s7;

endmodule
